// ===== rtl/sha256_byte_stream_hasher_core_assert.svh =====
// Assertion macros used by the checker file of the hasher core
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH

// clocked assertion with explicit clock and active-low reset
`define SBSH_ASSERT_CLK(label, ck, rst_n, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion on the local clk and arst_n
`define SBSH_ASSERT(label, prop, msg) \
	`SBSH_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ===== rtl/sbsh_pkg.sv =====
// Package of the SHA-256 byte stream hasher: states, round constants, initial hash
package sbsh_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;
	localparam logic [5:0] BLK_END  = 6'd63;

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

endpackage

// ===== rtl/sbsh_if.sv =====
// Valid/ready channel interfaces for message bytes and digest words
interface sbsh_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_valid;
	logic       last_byte;

	modport source (output valid, output data_byte, output byte_valid, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input byte_valid, input last_byte,
		output ready);
endinterface

interface sbsh_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  word_index;
	logic [63:0] digest_word;
	logic        last_word;

	modport source (output valid, output word_index, output digest_word, output last_word,
		input ready);
	modport sink (input valid, input word_index, input digest_word, input last_word,
		output ready);
endinterface

// ===== rtl/sha256_byte_stream_hasher_core.sv =====
// SHA-256 byte stream hasher: one byte per request, one round per cycle
// After the 64th byte of a block, the shared round unit runs the 64 rounds, then the
//   hash words are updated in ST_ADD.
// Closing: each padded block is filled with padding bytes, then runs the rounds
//   (two blocks if 56+ bytes are pending), then 4 digest words, at most one per cycle.
// Bytes are taken only in ST_IDLE, so the input stalls while a block runs the rounds.
// Reset: async, hash words to the initial values, byte count and sequencer cleared.
module sha256_byte_stream_hasher_core
	import sbsh_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	sbsh_in_if.sink     byte_in,
	sbsh_out_if.source  digest_out
);

	state_t      state_q, state_d;
	logic [31:0] hash_q [8];
	logic [31:0] v_q [8];
	logic [31:0] win_q [16];
	logic [23:0] wacc_q;
	logic [5:0]  pos_q;
	logic [5:0]  rnd_q;
	logic [60:0] bcnt_q;
	logic [63:0] len_q;
	logic        fin_q, mark_q, extra_q, done_q;
	logic [1:0]  widx_q;

	logic        in_acc, out_acc;
	logic        pad_len;
	logic [7:0]  pad_byte, ab_byte;
	logic        ab_en, blk_full;
	logic [60:0] bcnt_nxt;
	logic [31:0] w_new, t1, t2;

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	assign in_acc  = byte_in.valid & byte_in.ready;
	assign out_acc = digest_out.valid & digest_out.ready;

	// padding: marker, zeros, then the bit length in the final block
	assign pad_len  = mark_q && !extra_q && (pos_q >= LEN_POS);
	assign pad_byte = !mark_q ? PAD_MARK : (pad_len ? len_q[63:56] : 8'h00);

	assign ab_en    = (state_q == ST_PAD) || (in_acc && byte_in.byte_valid);
	assign ab_byte  = (state_q == ST_PAD) ? pad_byte : byte_in.data_byte;
	assign blk_full = ab_en && (pos_q == BLK_END);
	assign bcnt_nxt = bcnt_q + 61'(byte_in.byte_valid);

	// shared round unit
	assign w_new = ssig1(win_q[14]) + win_q[9] + ssig0(win_q[1]) + win_q[0];
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ ROUND_K[rnd_q] + win_q[0];
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (blk_full)
					state_d = ST_ROUND;
				else if (in_acc && byte_in.last_byte)
					state_d = ST_PAD;
			end
			ST_PAD: begin
				if (blk_full)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (rnd_q == BLK_END)
					state_d = ST_ADD;
			end
			ST_ADD: begin
				if (done_q)
					state_d = ST_EMIT;
				else if (fin_q)
					state_d = ST_PAD;
				else
					state_d = ST_IDLE;
			end
			ST_EMIT: begin
				if (out_acc && digest_out.last_word)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		byte_in.ready          = (state_q == ST_IDLE);
		digest_out.valid       = (state_q == ST_EMIT);
		digest_out.word_index  = widx_q;
		digest_out.digest_word = {hash_q[{widx_q, 1'b0}], hash_q[{widx_q, 1'b1}]};
		digest_out.last_word   = (widx_q == 2'd3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q   <= '0;
			rnd_q   <= '0;
			bcnt_q  <= '0;
			fin_q   <= 1'b0;
			mark_q  <= 1'b0;
			extra_q <= 1'b0;
			done_q  <= 1'b0;
			widx_q  <= '0;
			for (int i = 0; i < 8; i++)
				hash_q[i] <= SHA_IV[i];
		end else begin
			state_q <= state_d;
			if (ab_en)
				pos_q <= pos_q + 6'd1;
			if (in_acc && byte_in.byte_valid)
				bcnt_q <= bcnt_nxt;
			if (in_acc && byte_in.last_byte)
				fin_q <= 1'b1;
			if (state_q == ST_PAD) begin
				if (!mark_q) begin
					mark_q  <= 1'b1;
					extra_q <= (pos_q >= LEN_POS) && (pos_q != BLK_END);
				end else if (pos_q == BLK_END) begin
					extra_q <= 1'b0;
					if (pad_len)
						done_q <= 1'b1;
				end
			end
			if (state_q == ST_ROUND)
				rnd_q <= rnd_q + 6'd1;
			if (state_q == ST_ADD) begin
				for (int i = 0; i < 8; i++)
					hash_q[i] <= hash_q[i] + v_q[i];
			end
			if (out_acc) begin
				widx_q <= widx_q + 2'd1;
				if (digest_out.last_word) begin
					bcnt_q  <= '0;
					fin_q   <= 1'b0;
					mark_q  <= 1'b0;
					extra_q <= 1'b0;
					done_q  <= 1'b0;
					for (int i = 0; i < 8; i++)
						hash_q[i] <= SHA_IV[i];
				end
			end
		end
	end

	// message schedule window, word assembly and working variables
	always_ff @(posedge clk) begin
		if (ab_en) begin
			wacc_q <= {wacc_q[15:0], ab_byte};
			if (pos_q[1:0] == 2'd3) begin
				for (int i = 0; i < 15; i++)
					win_q[i] <= win_q[i + 1];
				win_q[15] <= {wacc_q, ab_byte};
			end
		end
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++)
				win_q[i] <= win_q[i + 1];
			win_q[15] <= w_new;
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (blk_full) begin
			for (int i = 0; i < 8; i++)
				v_q[i] <= hash_q[i];
		end
		if (in_acc && byte_in.last_byte)
			len_q <= {bcnt_nxt, 3'b000};
		else if ((state_q == ST_PAD) && pad_len)
			len_q <= {len_q[55:0], 8'h00};
	end

endmodule

// ===== rtl/sbsh_checker.sv =====
// Port-level checker for the hasher core, bound to the hasher core module
`include "sha256_byte_stream_hasher_core_assert.svh"

module sbsh_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] word_index,
	input logic       last_word
);

	// no new request taken while the digest is being handed out
	`SBSH_ASSERT(a_no_overlap, !(in_ready && out_valid), "input ready during digest output")

	`SBSH_ASSERT(a_last_idx, out_valid |-> (last_word == (word_index == 2'd3)), "last_word mismatch")

	`SBSH_ASSERT(a_first_idx, $rose(out_valid) |-> (word_index == 2'd0), "digest not starting at word 0")

	`SBSH_ASSERT(a_idx_step, (out_valid && out_ready && !last_word) |=> (out_valid && (word_index == 2'($past(word_index) + 2'd1))), "digest word skipped")

	`SBSH_ASSERT(a_end, (out_valid && out_ready && last_word) |=> (!out_valid && in_ready), "digest not closed")

endmodule

bind sha256_byte_stream_hasher_core sbsh_checker u_sbsh_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (byte_in.ready),
	.out_valid  (digest_out.valid),
	.out_ready  (digest_out.ready),
	.word_index (digest_out.word_index),
	.last_word  (digest_out.last_word)
);
